### hw/rtl/vfrq_pkg.sv
// shared types and constants for the variable frame ring queue
// no dependencies; imported by every module of the block
package vfrq_pkg;

  // store geometry
  localparam int unsigned STORE_DEPTH     = 1024;
  localparam int unsigned STORE_AW        = $clog2(STORE_DEPTH);
  localparam int unsigned PTR_W           = 11;
  localparam int unsigned SUM_W           = PTR_W + 1;
  localparam int unsigned MAX_FRAME_WORDS = 63;
  localparam int unsigned FW_W            = 6;
  localparam int unsigned WORD_W          = 32;

  // configuration register
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned CAP_RESET  = 1024;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;
  localparam logic [0:0]  REG_CAPACITY = 1'b0;

  // commands
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FIT   = 2'd2,
    CMD_CLEAR = 2'd3
  } vfrq_cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_NO_ROOM_WRAP = 3'd1,
    STAT_NO_ROOM_HEAD = 3'd2,
    STAT_EMPTY        = 3'd3,
    STAT_FITS         = 3'd4,
    STAT_NO_FIT       = 3'd5
  } vfrq_status_e;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } vfrq_state_e;

  // request payload
  typedef struct packed {
    vfrq_cmd_e         command;
    logic [7:0]        frame_bytes;
    logic [WORD_W-1:0] data_word;
  } vfrq_req_t;

  // result payload
  typedef struct packed {
    vfrq_status_e      status;
    logic [WORD_W-1:0] read_word;
    logic              last;
  } vfrq_rsp_t;

  // controller to store
  typedef struct packed {
    logic                we;
    logic                tag_we;
    logic [STORE_AW-1:0] waddr;
    logic [WORD_W-1:0]   wdata;
    logic [FW_W-1:0]     wtag;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } vfrq_mem_req_t;

  // store to controller
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [FW_W-1:0]   tag;
  } vfrq_mem_rsp_t;

endpackage

### hw/rtl/variable_frame_ring_queue_core.sv
// top level of the variable frame ring queue
// depends on vfrq_pkg, vfrq_cfg, vfrq_store, vfrq_ctrl
//
//   channel   handshake                       payload
//   request   start / busy                    req_i  (vfrq_req_t)
//   result    result_valid_o, one cycle       rsp_o  (vfrq_rsp_t)
//   config    apb psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// push, check and clear give their result in the cycle after the request,
// and the next request can be taken in that same cycle.
// a pop of a frame does one frame memory read per cycle and holds busy high
// while it streams; each word comes out through the registered read and the
// result register. reset clears pointers and control only; both memories
// stay undefined until written. results cannot be stalled by the receiver.
module variable_frame_ring_queue_core import vfrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vfrq_req_t         req_i,
  output logic              result_valid_o,
  output vfrq_rsp_t         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [PTR_W-1:0] cap_eff;
  vfrq_mem_req_t    mem_req;
  vfrq_mem_rsp_t    mem_rsp;

  // configuration
  vfrq_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_eff_o (cap_eff)
  );

  // frame and tag memories
  vfrq_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

  // pointer logic and pop sequencer
  vfrq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cap_eff_i      (cap_eff),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .mem_req_o      (mem_req),
    .mem_rsp_i      (mem_rsp)
  );

endmodule

### hw/rtl/vfrq_store.sv
// frame word memory and length tag memory, one write and one read port each
// depends on vfrq_pkg
module vfrq_store import vfrq_pkg::*; (
  input  logic          clk_i,
  input  vfrq_mem_req_t mem_req_i,
  output vfrq_mem_rsp_t mem_rsp_o
);

  logic [WORD_W-1:0] word_mem [STORE_DEPTH];
  logic [FW_W-1:0]   tag_mem  [STORE_DEPTH];
  vfrq_mem_rsp_t     rsp_q;

  // writes
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      word_mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    if (mem_req_i.tag_we) begin
      tag_mem[mem_req_i.waddr] <= mem_req_i.wtag;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rsp_q.word <= word_mem[mem_req_i.raddr];
      rsp_q.tag  <= tag_mem[mem_req_i.raddr];
    end
  end

  assign mem_rsp_o = rsp_q;

endmodule

### hw/rtl/vfrq_cfg.sv
// apb configuration register: ring capacity in words
// depends on vfrq_pkg
module vfrq_cfg import vfrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [PTR_W-1:0]  cap_eff_o
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CAPACITY);

  // register write
  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else begin
      cap_q <= cap_d;
    end
  end

  // read decode
  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_CAPACITY: prdata = APB_DW'(cap_q);
      default:      prdata = '0;
    endcase
  end

  // capacity limited to the store depth
  assign cap_eff_o = (cap_q > CAP_W'(STORE_DEPTH)) ? PTR_W'(STORE_DEPTH) : PTR_W'(cap_q);

endmodule

### hw/rtl/vfrq_ctrl.sv
// ring pointers, frame allocation, push tracking and pop sequencer
// depends on vfrq_pkg; drives the store through vfrq_mem_req_t
module vfrq_ctrl import vfrq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vfrq_req_t        req_i,
  input  logic [PTR_W-1:0] cap_eff_i,
  output logic             result_valid_o,
  output vfrq_rsp_t        rsp_o,
  output vfrq_mem_req_t    mem_req_o,
  input  vfrq_mem_rsp_t    mem_rsp_i
);

  vfrq_state_e state_q, state_d;

  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [PTR_W-1:0]    wrap_q, wrap_d;
  logic [STORE_AW-1:0] push_wpos_q, push_wpos_d;
  logic [FW_W-1:0]     push_seen_q, push_seen_d;
  logic                push_drop_q, push_drop_d;
  logic [STORE_AW-1:0] pop_addr_q, pop_addr_d;
  logic [FW_W-1:0]     pop_idx_q, pop_idx_d;
  logic [FW_W-1:0]     pop_n_q, pop_n_d;
  logic                pop_wrap_q, pop_wrap_d;
  logic                res_valid_q, res_valid_d;
  vfrq_rsp_t           res_q, res_d;

  logic                accept;
  logic                empty;
  logic [8:0]          w_raw;
  logic [FW_W-1:0]     w;
  logic [SUM_W-1:0]    tail_plus_w;
  logic                place_tail, place_wrap;
  vfrq_status_e        place_fail;
  logic                drop_now;
  logic [STORE_AW-1:0] wpos;
  vfrq_status_e        push_st;
  logic [FW_W:0]       seen_next;
  logic [FW_W-1:0]     n_cur;
  logic                pop_last;
  logic                wrapped;
  logic [STORE_AW-1:0] start_addr;

  assign accept = start && !busy;
  assign busy   = (state_q == ST_POP);
  assign empty  = (head_q == tail_q);

  // frame length in words, clamped
  assign w_raw = ({1'b0, req_i.frame_bytes} + 9'd3) >> 2;
  always_comb begin
    if (w_raw == 9'd0) begin
      w = FW_W'(1);
    end else if (w_raw > 9'(MAX_FRAME_WORDS)) begin
      w = FW_W'(MAX_FRAME_WORDS);
    end else begin
      w = w_raw[FW_W-1:0];
    end
  end

  // placement decision
  assign tail_plus_w = {1'b0, tail_q} + SUM_W'(w);
  always_comb begin
    place_tail = 1'b0;
    place_wrap = 1'b0;
    place_fail = STAT_NO_ROOM_WRAP;
    if (head_q <= tail_q) begin
      if (tail_plus_w <= {1'b0, cap_eff_i}) begin
        place_tail = 1'b1;
      end else if (head_q > PTR_W'(w)) begin
        place_wrap = 1'b1;
      end
    end else begin
      place_fail = STAT_NO_ROOM_HEAD;
      if (tail_plus_w < {1'b0, head_q}) begin
        place_tail = 1'b1;
      end
    end
  end

  // pop run bookkeeping
  assign n_cur      = (pop_idx_q == '0) ? ((mem_rsp_i.tag == '0) ? FW_W'(1) : mem_rsp_i.tag)
                                        : pop_n_q;
  assign pop_last   = (({1'b0, pop_idx_q} + 7'd1) == {1'b0, n_cur});
  assign wrapped    = (head_q >= wrap_q);
  assign start_addr = wrapped ? '0 : head_q[STORE_AW-1:0];

  // push word bookkeeping
  assign seen_next = {1'b0, push_seen_q} + 7'd1;
  always_comb begin
    drop_now = push_drop_q;
    wpos     = push_wpos_q;
    push_st  = STAT_OK;
    if (push_seen_q == '0) begin
      if (place_tail) begin
        drop_now = 1'b0;
        wpos     = tail_q[STORE_AW-1:0];
      end else if (place_wrap) begin
        drop_now = 1'b0;
        wpos     = '0;
      end else begin
        drop_now = 1'b1;
        push_st  = place_fail;
      end
    end else if (push_drop_q) begin
      push_st = STAT_NO_ROOM_WRAP;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.command == CMD_POP) && !empty) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (pop_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    wrap_d      = wrap_q;
    push_wpos_d = push_wpos_q;
    push_seen_d = push_seen_q;
    push_drop_d = push_drop_q;
    pop_addr_d  = pop_addr_q;
    pop_idx_d   = pop_idx_q;
    pop_n_d     = pop_n_q;
    pop_wrap_d  = pop_wrap_q;
    res_valid_d = 1'b0;
    res_d       = '{status: STAT_OK, read_word: '0, last: 1'b1};
    mem_req_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.command)
            CMD_PUSH: begin
              res_valid_d = 1'b1;
              res_d.status = push_st;
              if (push_seen_q == '0) begin
                if (place_tail) begin
                  tail_d = tail_plus_w[PTR_W-1:0];
                end else if (place_wrap) begin
                  wrap_d = tail_q;
                  tail_d = PTR_W'(w);
                end
                mem_req_o.tag_we = !drop_now;
                mem_req_o.wtag   = w;
              end
              if (!drop_now) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = wpos;
                mem_req_o.wdata = req_i.data_word;
                push_wpos_d     = wpos + STORE_AW'(1);
              end
              if (seen_next >= {1'b0, w}) begin
                push_seen_d = '0;
                push_drop_d = 1'b0;
              end else begin
                push_seen_d = seen_next[FW_W-1:0];
                push_drop_d = drop_now;
              end
            end
            CMD_POP: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_d.status = STAT_EMPTY;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = start_addr;
                pop_addr_d      = start_addr + STORE_AW'(1);
                pop_idx_d       = '0;
                pop_wrap_d      = wrapped;
              end
            end
            CMD_FIT: begin
              res_valid_d  = 1'b1;
              res_d.status = (place_tail || place_wrap) ? STAT_FITS : STAT_NO_FIT;
            end
            CMD_CLEAR: begin
              res_valid_d = 1'b1;
              head_d      = '0;
              tail_d      = '0;
              wrap_d      = cap_eff_i;
              push_wpos_d = '0;
              push_seen_d = '0;
              push_drop_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        // stream one word per cycle, prefetch the next address
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = pop_addr_q;
        pop_addr_d      = pop_addr_q + STORE_AW'(1);
        pop_idx_d       = pop_idx_q + FW_W'(1);
        pop_n_d         = n_cur;
        res_valid_d     = 1'b1;
        res_d.read_word = mem_rsp_i.word;
        res_d.last      = pop_last;
        if (pop_last) begin
          if (pop_wrap_q) begin
            head_d = PTR_W'(n_cur);
            wrap_d = cap_eff_i;
          end else begin
            head_d = head_q + PTR_W'(n_cur);
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      wrap_q      <= PTR_W'(CAP_RESET);
      push_wpos_q <= '0;
      push_seen_q <= '0;
      push_drop_q <= 1'b0;
      pop_idx_q   <= '0;
      pop_wrap_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      wrap_q      <= wrap_d;
      push_wpos_q <= push_wpos_d;
      push_seen_q <= push_seen_d;
      push_drop_q <= push_drop_d;
      pop_idx_q   <= pop_idx_d;
      pop_wrap_q  <= pop_wrap_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pop_addr_q <= pop_addr_d;
    pop_n_q    <= pop_n_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign rsp_o          = res_q;

  // single-result commands answer in the next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.command != CMD_POP) |=> result_valid_o && rsp_o.last)
    else $error("single-result request gave no final result");

  // head holds inside a pop run and moves only at its end
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) && !pop_last |=> $stable(head_q))
    else $error("head moved inside a pop run");

  // tail never passes the end of the store
  a_tail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= PTR_W'(STORE_DEPTH))
    else $error("tail beyond store depth");

  // partial frame count stays below the frame limit
  a_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_seen_q < FW_W'(MAX_FRAME_WORDS))
    else $error("push word count out of range");

  // a pop run always keeps the read port busy
  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> mem_req_o.re && !mem_req_o.we)
    else $error("pop run without store read");

endmodule

### tb/vfrq_ring_checker.sv
// result checker for the variable frame ring queue: tracks ring state and compares results
// depends on vfrq_pkg; watches the request, result and apb write channels of the core
module vfrq_ring_checker import vfrq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  vfrq_req_t         req_i,
  input  logic              result_valid_i,
  input  vfrq_rsp_t         rsp_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o
);

  // where a new frame can go
  typedef enum logic [1:0] {
    SLOT_AT_TAIL,
    SLOT_AT_ZERO,
    SLOT_NONE_WRAP,
    SLOT_NONE_HEAD
  } slot_e;

  // shadow ring state
  logic [WORD_W-1:0] ring_words [STORE_DEPTH];
  logic [FW_W-1:0]   ring_tags  [STORE_DEPTH];
  int unsigned       cap_words;
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       wrap_at;
  int unsigned       fill_pos;
  int unsigned       words_seen;
  bit                dropping;
  vfrq_rsp_t         due_results [$];

  // capacity as seen by the fit tests
  function automatic int unsigned usable_words();
    return (cap_words > STORE_DEPTH) ? STORE_DEPTH : cap_words;
  endfunction

  function automatic int unsigned frame_words(logic [7:0] nbytes);
    int unsigned w;
    w = (32'(nbytes) + 32'd3) >> 2;
    if (w < 1) w = 1;
    if (w > MAX_FRAME_WORDS) w = MAX_FRAME_WORDS;
    return w;
  endfunction

  // no split across the ring end: at tail, else at zero if head lies beyond
  function automatic slot_e find_slot(int unsigned w);
    if (head_idx <= tail_idx) begin
      if (tail_idx + w <= usable_words()) return SLOT_AT_TAIL;
      if (head_idx > w) return SLOT_AT_ZERO;
      return SLOT_NONE_WRAP;
    end
    if (tail_idx + w < head_idx) return SLOT_AT_TAIL;
    return SLOT_NONE_HEAD;
  endfunction

  // apply one request to the shadow ring and queue the results it owes
  task automatic apply_request(vfrq_req_t r);
    vfrq_rsp_t   res;
    int unsigned w;
    int unsigned n;
    int unsigned base;
    slot_e       slot;
    bit          wrapped;
    w = frame_words(r.frame_bytes);
    res = '0;
    res.status = STAT_OK;
    res.last = 1'b1;
    case (r.command)
      CMD_PUSH: begin
        // first word of a frame allocates the whole frame
        if (words_seen == 0) begin
          slot = find_slot(w);
          dropping = 1'b0;
          case (slot)
            SLOT_AT_TAIL: begin
              fill_pos = tail_idx;
              tail_idx += w;
            end
            SLOT_AT_ZERO: begin
              wrap_at = tail_idx;
              tail_idx = w;
              fill_pos = 0;
            end
            SLOT_NONE_WRAP: begin
              dropping = 1'b1;
              res.status = STAT_NO_ROOM_WRAP;
            end
            default: begin
              dropping = 1'b1;
              res.status = STAT_NO_ROOM_HEAD;
            end
          endcase
          if (!dropping) ring_tags[fill_pos % STORE_DEPTH] = FW_W'(w);
        end else if (dropping) begin
          res.status = STAT_NO_ROOM_WRAP;
        end
        if (!dropping) begin
          ring_words[fill_pos % STORE_DEPTH] = r.data_word;
          fill_pos = (fill_pos + 1) & 32'hFFFF;
        end
        words_seen++;
        if (words_seen >= w) begin
          words_seen = 0;
          dropping = 1'b0;
        end
        due_results.push_back(res);
      end
      CMD_POP: begin
        if (head_idx == tail_idx) begin
          res.status = STAT_EMPTY;
          due_results.push_back(res);
        end else begin
          // reader jumps to zero once it reaches the wrap mark
          wrapped = head_idx >= wrap_at;
          base = wrapped ? 0 : head_idx;
          n = ring_tags[base % STORE_DEPTH];
          if (n < 1) n = 1;
          for (int unsigned i = 0; i < n; i++) begin
            res.read_word = ring_words[(base + i) % STORE_DEPTH];
            res.last = (i + 1 == n);
            due_results.push_back(res);
          end
          if (wrapped) begin
            head_idx = n;
            wrap_at = usable_words();
          end else begin
            head_idx = (head_idx + n) & 32'hFFFF;
          end
        end
      end
      CMD_FIT: begin
        slot = find_slot(w);
        res.status = (slot == SLOT_AT_TAIL || slot == SLOT_AT_ZERO) ? STAT_FITS : STAT_NO_FIT;
        due_results.push_back(res);
      end
      default: begin
        head_idx = 0;
        tail_idx = 0;
        wrap_at = usable_words();
        fill_pos = 0;
        words_seen = 0;
        dropping = 1'b0;
        due_results.push_back(res);
      end
    endcase
  endtask

  // compare one result with the oldest expectation
  task automatic compare_result();
    vfrq_rsp_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: status %0d read_word %08h last %0d",
             rsp_i.status, rsp_i.read_word, rsp_i.last);
      mismatches_o++;
    end else begin
      want = due_results.pop_front();
      if (rsp_i.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, rsp_i.status);
        mismatches_o++;
      end
      if (rsp_i.read_word !== want.read_word) begin
        $error("read_word: expected %08h, got %08h", want.read_word, rsp_i.read_word);
        mismatches_o++;
      end
      if (rsp_i.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, rsp_i.last);
        mismatches_o++;
      end
    end
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_words = CAP_RESET;
      head_idx = 0;
      tail_idx = 0;
      wrap_at = CAP_RESET;
      fill_pos = 0;
      words_seen = 0;
      dropping = 1'b0;
      due_results.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (result_valid_i === 1'b1) compare_result();
      if (start_i === 1'b1 && busy_i === 1'b0) apply_request(req_i);
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] == REG_CAPACITY) begin
        cap_words = 32'(pwdata_i[CAP_W-1:0]);
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

### tb/variable_frame_ring_queue_core_tb.sv
// testbench top for the variable frame ring queue: request stimulus and verdict
// depends on vfrq_pkg, variable_frame_ring_queue_core and vfrq_ring_checker
module variable_frame_ring_queue_core_tb;
  import vfrq_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  vfrq_req_t         req_i;
  logic              result_valid;
  vfrq_rsp_t         rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       items_sent;
  bit                steady;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  variable_frame_ring_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid),
    .rsp_o          (rsp),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  vfrq_ring_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req_i),
    .result_valid_i (result_valid),
    .rsp_i          (rsp),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  // one request, after a random gap; returns at the edge that takes it
  task automatic send(input vfrq_cmd_e cmd, input logic [7:0] nbytes,
                      input logic [WORD_W-1:0] word);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{command: cmd, frame_bytes: nbytes, data_word: word};
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
  endtask

  // hold off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  // apb write of the ring capacity: setup then access
  task automatic write_capacity(input int unsigned value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // push a whole frame; after word number turn the byte count becomes later
  task automatic push_frame(input logic [7:0] nbytes, input int unsigned turn,
                            input logic [7:0] later);
    logic [7:0]  b;
    int unsigned sent;
    int unsigned words;
    bit          closed;
    b = nbytes;
    sent = 0;
    do begin
      if ($urandom_range(0, 9) == 0) send(CMD_FIT, 8'($urandom), $urandom);
      send(CMD_PUSH, b, $urandom);
      sent++;
      words = (32'(b) + 32'd3) >> 2;
      closed = (sent >= words) || (sent >= MAX_FRAME_WORDS);
      if (sent == turn) b = later;
    end while (!closed);
  endtask

  // mostly short frames, a few up to the largest
  function automatic logic [7:0] frame_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return 8'($urandom_range(0, 32));
    if (pick < 97) return 8'($urandom_range(33, 120));
    return 8'($urandom_range(121, 255));
  endfunction

  // stimulus
  initial begin
    int unsigned caps [8];
    int unsigned phase_end;
    int unsigned pick;
    logic [7:0]  base;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    steady = 1'b0;
    caps = '{1024, 40, 0, 1, 2047, 17, 0, 64};
    caps[6] = $urandom_range(4, 120);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty pop, fit extremes, data extremes in one-word frames
    send(CMD_POP, 8'd0, '0);
    send(CMD_FIT, 8'd0, '0);
    send(CMD_FIT, 8'd255, '1);
    send(CMD_PUSH, 8'd0, '0);
    send(CMD_PUSH, 8'd1, '1);
    send(CMD_POP, 8'd255, '1);
    send(CMD_POP, 8'd0, '0);

    // six-word ring: full tail, wrap to zero, no room before head, dropped words
    drain_results();
    write_capacity(6);
    send(CMD_CLEAR, 8'd0, '0);
    push_frame(8'd16, 0, 8'd0);
    push_frame(8'd8, 0, 8'd0);
    send(CMD_FIT, 8'd4, '0);
    send(CMD_PUSH, 8'd4, $urandom);
    send(CMD_POP, 8'd0, '0);
    push_frame(8'd12, 0, 8'd0);
    push_frame(8'd8, 0, 8'd0);
    send(CMD_POP, 8'd0, '0);
    send(CMD_POP, 8'd0, '0);

    // random phases, one capacity each
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_capacity(caps[ph]);
      send(CMD_CLEAR, 8'($urandom), $urandom);
      phase_end = items_sent + 50;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          push_frame(frame_size(), 0, 8'd0);
        end else if (pick < 72) begin
          send(CMD_POP, 8'($urandom), $urandom);
        end else if (pick < 80) begin
          send(CMD_FIT, 8'($urandom), $urandom);
        end else if (pick < 84) begin
          send(CMD_CLEAR, 8'($urandom), $urandom);
        end else if (pick < 89) begin
          // frame that grows after its first word
          base = 8'($urandom_range(5, 24));
          push_frame(base, 1, base + 8'($urandom_range(4, 40)));
        end else if (pick < 93) begin
          // frame cut short by a smaller byte count, then cleared
          push_frame(8'($urandom_range(20, 60)), $urandom_range(2, 4),
                     8'($urandom_range(0, 8)));
          send(CMD_CLEAR, 8'($urandom), $urandom);
        end else if (pick < 97) begin
          // frame abandoned by a clear
          base = 8'($urandom_range(20, 80));
          repeat ($urandom_range(1, 4)) send(CMD_PUSH, base, $urandom);
          send(CMD_CLEAR, 8'($urandom), $urandom);
        end else begin
          drain_results();
        end
      end
    end

    // wait out the last results, then a longest pop more
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (MAX_FRAME_WORDS + 16) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
